// ----- rtl/ost_pkg.sv -----
`timescale 1ns / 1ps
package ost_pkg;

  localparam int unsigned DefTableEntries = 64;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned VENUE_W = 8;
  localparam int unsigned SYM_W   = 16;
  localparam int unsigned QTY_W   = 48;

  typedef enum logic [1:0] {
    CMD_REQUEST,
    CMD_FILL,
    CMD_ACK,
    CMD_REJECT
  } cmd_t;

  typedef enum logic [3:0] {
    EV_DROPPED,
    EV_CANCEL_HIT,
    EV_CANCEL_MISS,
    EV_MODIFIED,
    EV_INSERTED,
    EV_FULL,
    EV_FILL,
    EV_FILL_MISS,
    EV_ACKED,
    EV_REJECTED
  } event_t;

  typedef enum logic [2:0] {
    ST_PENDING,
    ST_ACCEPTED,
    ST_PARTIAL,
    ST_FILLED,
    ST_CANCELLED,
    ST_REJECTED,
    ST_NONE
  } status_t;

  typedef enum logic [1:0] {
    ES_PENDING,
    ES_ACCEPTED,
    ES_PARTIAL
  } ent_status_t;

  typedef enum logic {
    REG_EXCHANGE_ID,
    REG_AUTO_FILL
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EXEC,
    S_FILL2
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    order_number;
    logic [SYM_W-1:0]   instrument;
    logic [SYM_W-1:0]   strategy;
    logic               buy_sell;
    logic [QTY_W-1:0]   price;
    logic [QTY_W-1:0]   original_amount;
    logic [QTY_W-1:0]   filled_amount;
    ent_status_t        status;
    logic [ID_W-1:0]    venue_number;
    logic               has_venue_number;
  } entry_t;

  typedef struct packed {
    event_t             ev;
    logic [ID_W-1:0]    order_number;
    logic [SYM_W-1:0]   instrument;
    logic [SYM_W-1:0]   strategy;
    logic               buy_sell;
    logic [QTY_W-1:0]   price;
    logic [QTY_W-1:0]   amount;
    status_t            status;
  } result_t;

endpackage

// ----- rtl/order_state_table.sv -----
`timescale 1ns / 1ps
// Order state table. Holds up to TABLE_ENTRIES live orders in one record memory
// with one read and one write port. Every beat scans the whole table, one
// entry per cycle through a single id/venue compare unit, then re-reads the
// chosen entry and does one read-modify-write, waiting if need be for the
// result register to drain. A new beat is taken only once the last one's
// result is loaded. An auto-filled insert gives two result beats, the second
// from the S_FILL2 state. After reset a clearing pass over every entry runs
// with in_ready low; config writes are taken anytime.
module order_state_table #(
  parameter int unsigned TABLE_ENTRIES = ost_pkg::DefTableEntries,
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ost_pkg::VENUE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [ost_pkg::ID_W-1:0]      order_number,
  input  logic [ost_pkg::VENUE_W-1:0]   venue,
  input  logic [ost_pkg::SYM_W-1:0]     instrument,
  input  logic [ost_pkg::SYM_W-1:0]     strategy,
  input  logic                          buy_sell,
  input  logic [ost_pkg::QTY_W-1:0]     limit_price,
  input  logic [ost_pkg::QTY_W-1:0]     amount,
  input  logic [ost_pkg::ID_W-1:0]      venue_order_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    event_res,
  output logic [ost_pkg::ID_W-1:0]      out_order_number,
  output logic [ost_pkg::SYM_W-1:0]     out_instrument,
  output logic [ost_pkg::SYM_W-1:0]     out_strategy,
  output logic                          out_buy_sell,
  output logic [ost_pkg::QTY_W-1:0]     out_price,
  output logic [ost_pkg::QTY_W-1:0]     out_amount,
  output logic [2:0]                    order_status,
  output logic [CNT_W-1:0]              live_count,
  output logic                          last
);
  import ost_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W:0] LastCnt = (IDX_W + 1)'(TABLE_ENTRIES);

  state_t state, state_next;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;
  entry_t wr_rec;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic wr_en;

  logic [IDX_W:0]   scan_cnt;
  logic             chk;
  logic [IDX_W-1:0] chk_idx;
  logic             local_hit, venue_hit, free_hit;
  logic [IDX_W-1:0] local_idx, venue_idx, free_idx;
  logic [IDX_W-1:0] sel_idx;

  cmd_t               cmd;
  logic [ID_W-1:0]    num;
  logic [VENUE_W-1:0] ven;
  logic [SYM_W-1:0]   ins;
  logic [SYM_W-1:0]   strat;
  logic               side;
  logic [QTY_W-1:0]   price;
  logic [QTY_W-1:0]   amt;
  logic [ID_W-1:0]    vnum;

  logic [VENUE_W-1:0] home_venue;
  logic               auto_fill_en;
  logic [CNT_W-1:0]   cnt, cnt_next;

  logic accept, slot_free, load_res;

  // exec decision
  entry_t           ex_rec;
  result_t          ex_res;
  logic             ex_wr, ex_fill2;
  logic [CNT_W-1:0] ex_cnt, ex_rep;
  logic [QTY_W:0]   fill_sum;
  logic [QTY_W-1:0] fill_new;
  logic             fill_done;

  result_t          res;
  logic [CNT_W-1:0] res_cnt;
  logic             res_last;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    unique case (cmd)
      CMD_REQUEST: sel_idx = local_hit ? local_idx : free_idx;
      CMD_FILL:    sel_idx = local_hit ? local_idx : venue_idx;
      default:     sel_idx = local_idx;
    endcase
  end

  always_comb begin
    fill_sum  = {1'b0, rd_data.filled_amount} + {1'b0, amt};
    fill_new  = fill_sum[QTY_W] ? '1 : fill_sum[QTY_W-1:0];
    fill_done = fill_new >= rd_data.original_amount;

    ex_rec   = rd_data;
    ex_wr    = 1'b0;
    ex_fill2 = 1'b0;
    ex_cnt   = cnt;

    ex_res.ev           = EV_DROPPED;
    ex_res.order_number = num;
    ex_res.instrument   = ins;
    ex_res.strategy     = strat;
    ex_res.buy_sell     = side;
    ex_res.price        = price;
    ex_res.amount       = amt;
    ex_res.status       = ST_NONE;

    unique case (cmd)
      CMD_REQUEST: begin
        if (ven != home_venue) begin
          ex_res.ev = EV_DROPPED;
        end else if (amt == '0) begin
          if (local_hit) begin
            ex_res.ev           = EV_CANCEL_HIT;
            ex_res.order_number = rd_data.order_number;
            ex_res.instrument   = rd_data.instrument;
            ex_res.strategy     = rd_data.strategy;
            ex_res.buy_sell     = rd_data.buy_sell;
            ex_res.price        = rd_data.price;
            ex_res.amount       = rd_data.original_amount;
            ex_res.status       = ST_CANCELLED;
            ex_rec.valid        = 1'b0;
            ex_wr               = 1'b1;
            ex_cnt              = cnt - CNT_W'(1);
          end else begin
            ex_res.ev = EV_CANCEL_MISS;
          end
        end else if (local_hit) begin
          ex_res.ev              = EV_MODIFIED;
          ex_res.order_number    = rd_data.order_number;
          ex_res.instrument      = rd_data.instrument;
          ex_res.strategy        = rd_data.strategy;
          ex_res.buy_sell        = rd_data.buy_sell;
          ex_res.status          = status_t'({1'b0, rd_data.status});
          ex_rec.price           = price;
          ex_rec.original_amount = amt;
          ex_wr                  = 1'b1;
        end else if (free_hit) begin
          ex_res.ev     = EV_INSERTED;
          ex_res.status = ST_PENDING;
          if (auto_fill_en) begin
            // fills at once, so the slot stays free
            ex_fill2 = 1'b1;
          end else begin
            ex_rec.valid            = 1'b1;
            ex_rec.order_number     = num;
            ex_rec.instrument       = ins;
            ex_rec.strategy         = strat;
            ex_rec.buy_sell         = side;
            ex_rec.price            = price;
            ex_rec.original_amount  = amt;
            ex_rec.filled_amount    = '0;
            ex_rec.status           = ES_PENDING;
            ex_rec.venue_number     = '0;
            ex_rec.has_venue_number = 1'b0;
            ex_wr                   = 1'b1;
            ex_cnt                  = cnt + CNT_W'(1);
          end
        end else begin
          ex_res.ev = EV_FULL;
        end
      end
      CMD_FILL: begin
        if (local_hit || venue_hit) begin
          ex_res.ev            = EV_FILL;
          ex_res.order_number  = rd_data.order_number;
          ex_res.instrument    = rd_data.instrument;
          ex_res.strategy      = rd_data.strategy;
          ex_res.buy_sell      = rd_data.buy_sell;
          ex_res.status        = fill_done ? ST_FILLED : ST_PARTIAL;
          ex_rec.filled_amount = fill_new;
          ex_wr                = 1'b1;
          if (fill_done) begin
            ex_rec.valid = 1'b0;
            ex_cnt       = cnt - CNT_W'(1);
          end else begin
            ex_rec.status = ES_PARTIAL;
          end
        end else begin
          ex_res.ev = EV_FILL_MISS;
        end
      end
      CMD_ACK: begin
        ex_res.ev = EV_ACKED;
        if (local_hit) begin
          ex_res.order_number = rd_data.order_number;
          ex_res.instrument   = rd_data.instrument;
          ex_res.strategy     = rd_data.strategy;
          ex_res.buy_sell     = rd_data.buy_sell;
          ex_res.price        = rd_data.price;
          ex_res.amount       = rd_data.original_amount;
          ex_res.status       = ST_ACCEPTED;
          ex_rec.status       = ES_ACCEPTED;
          if (vnum != '0) begin
            ex_rec.venue_number     = vnum;
            ex_rec.has_venue_number = 1'b1;
          end
          ex_wr = 1'b1;
        end
      end
      CMD_REJECT: begin
        ex_res.ev = EV_REJECTED;
        if (local_hit) begin
          ex_res.order_number = rd_data.order_number;
          ex_res.instrument   = rd_data.instrument;
          ex_res.strategy     = rd_data.strategy;
          ex_res.buy_sell     = rd_data.buy_sell;
          ex_res.price        = rd_data.price;
          ex_res.amount       = rd_data.original_amount;
          ex_res.status       = ST_REJECTED;
          ex_rec.valid        = 1'b0;
          ex_wr               = 1'b1;
          ex_cnt              = cnt - CNT_W'(1);
        end
      end
    endcase

    ex_rep = ex_fill2 ? cnt + CNT_W'(1) : ex_cnt;
  end

  always_comb begin
    state_next = state;
    rd_addr    = scan_cnt[IDX_W-1:0];
    wr_addr    = sel_idx;
    wr_rec     = ex_rec;
    wr_en      = 1'b0;
    load_res   = 1'b0;
    cnt_next   = cnt;
    res        = ex_res;
    res_cnt    = ex_rep;
    res_last   = 1'b1;

    unique case (state)
      S_CLEAR: begin
        wr_addr = scan_cnt[IDX_W-1:0];
        wr_rec  = '0;
        wr_en   = (scan_cnt != LastCnt);
        if (scan_cnt == LastCnt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == LastCnt && !chk) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        rd_addr    = sel_idx;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        rd_addr  = sel_idx;
        res_last = !ex_fill2;
        if (slot_free) begin
          load_res   = 1'b1;
          wr_en      = ex_wr;
          cnt_next   = ex_cnt;
          state_next = ex_fill2 ? S_FILL2 : S_IDLE;
        end
      end
      S_FILL2: begin
        res.ev           = EV_FILL;
        res.order_number = num;
        res.instrument   = ins;
        res.strategy     = strat;
        res.buy_sell     = side;
        res.price        = price;
        res.amount       = amt;
        res.status       = ST_FILLED;
        res_cnt          = cnt;
        if (slot_free) begin
          load_res   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_venue   <= '0;
      auto_fill_en <= 1'b0;
      cnt          <= '0;
      out_valid    <= 1'b0;
      scan_cnt     <= '0;
      chk          <= 1'b0;
      local_hit    <= 1'b0;
      venue_hit    <= 1'b0;
      free_hit     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_EXCHANGE_ID) begin
          home_venue <= cfg_data;
        end else begin
          auto_fill_en <= cfg_data[0];
        end
      end

      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      cnt <= cnt_next;

      if (state == S_IDLE) begin
        scan_cnt <= '0;
      end else if ((state == S_SCAN || state == S_CLEAR) && scan_cnt != LastCnt) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      chk <= (state == S_SCAN) && (scan_cnt != LastCnt);

      if (accept) begin
        local_hit <= 1'b0;
        venue_hit <= 1'b0;
        free_hit  <= 1'b0;
      end else if (state == S_SCAN && chk) begin
        if (rd_data.valid && rd_data.order_number == num && !local_hit) begin
          local_hit <= 1'b1;
        end
        if (rd_data.valid && rd_data.has_venue_number && rd_data.venue_number == vnum
            && !venue_hit) begin
          venue_hit <= 1'b1;
        end
        if (!rd_data.valid && !free_hit) begin
          free_hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= cmd_t'(command);
      num   <= order_number;
      ven   <= venue;
      ins   <= instrument;
      strat <= strategy;
      side  <= buy_sell;
      price <= limit_price;
      amt   <= amount;
      vnum  <= venue_order_number;
    end

    chk_idx <= scan_cnt[IDX_W-1:0];
    if (state == S_SCAN && chk) begin
      if (rd_data.valid && rd_data.order_number == num && !local_hit) begin
        local_idx <= chk_idx;
      end
      if (rd_data.valid && rd_data.has_venue_number && rd_data.venue_number == vnum
          && !venue_hit) begin
        venue_idx <= chk_idx;
      end
      if (!rd_data.valid && !free_hit) begin
        free_idx <= chk_idx;
      end
    end

    if (load_res) begin
      event_res        <= res.ev;
      out_order_number <= res.order_number;
      out_instrument   <= res.instrument;
      out_strategy     <= res.strategy;
      out_buy_sell     <= res.buy_sell;
      out_price        <= res.price;
      out_amount       <= res.amount;
      order_status     <= res.status;
      live_count       <= res_cnt;
      last             <= res_last;
    end
  end

endmodule
